// File: sv/fpwc_pkg.sv
// Shared types and constants for the flow pulse window classifier.
// Used by every module of the block; depends on nothing else.
package fpwc_pkg;

  localparam int unsigned COUNT_W = 24;
  localparam int unsigned RATE_W  = 20;
  localparam int unsigned CLASS_W = 2;
  localparam int unsigned CFG_IDX_W = 2;

  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [RATE_W-1:0]  rate_t;
  typedef logic [CLASS_W-1:0] class_t;
  typedef logic [2:0]         rep_class_t;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SAMPLES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SLOW_THRESHOLD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FAST_THRESHOLD = 2'd2;

  // Register reset values.
  localparam count_t WINDOW_SAMPLES_RST = 24'd1500000;
  localparam rate_t  SLOW_THRESHOLD_RST = 20'd5;
  localparam rate_t  FAST_THRESHOLD_RST = 20'd30;

  // Flow classes.
  localparam class_t CLASS_NONE = 2'd0;
  localparam class_t CLASS_SLOW = 2'd1;
  localparam class_t CLASS_FAST = 2'd2;

  // Reported class before anything has been reported.
  localparam rep_class_t NONE_REPORTED = 3'd4;

  // Division by 18: halve, then multiply by ceil(2^27 / 9) and drop 27 bits.
  // The reciprocal exceeds 2^27 / 9 by 1/9, and the halved count stays below
  // 2^23, so the product floors to the exact quotient.
  localparam int unsigned HALF_W     = COUNT_W - 1;
  localparam int unsigned RECIP_W    = 24;
  localparam int unsigned RECIP_SHIFT = 27;
  localparam int unsigned PROD_W     = HALF_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RATE_RECIP = 24'd14913081;

  typedef struct packed {
    rate_t  flow_rate;
    class_t flow_class;
    logic   lamp_on;
    logic   stable;
    logic   report;
  } result_t;

endpackage

// File: sv/fpwc_window.sv
// Window stage: edge counting and sample counting over one window.
// Depends on fpwc_pkg. Emits the change count of each finished window.
module fpwc_window (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_pin_level,
  input  fpwc_pkg::count_t  window_samples,
  output logic              win_valid,
  input  logic              win_ready,
  output fpwc_pkg::count_t  win_changes
);

  logic             last_level_r, last_level_nxt;
  fpwc_pkg::count_t change_count_r, change_count_nxt;
  fpwc_pkg::count_t sample_count_r, sample_count_nxt;
  logic             win_valid_r, win_valid_nxt;
  fpwc_pkg::count_t win_changes_r, win_changes_nxt;

  fpwc_pkg::count_t limit;
  fpwc_pkg::count_t chg_upd;
  fpwc_pkg::count_t smp_upd;
  logic             accept;
  logic             window_end;

  assign in_ready    = !win_valid_r || win_ready;
  assign accept      = in_valid && in_ready;
  assign win_valid   = win_valid_r;
  assign win_changes = win_changes_r;

  always_comb begin
    // A zero window behaves as a one-sample window.
    limit   = (window_samples == '0) ? fpwc_pkg::count_t'(1) : window_samples;
    chg_upd = (in_pin_level != last_level_r) ? change_count_r + 1'b1 : change_count_r;
    smp_upd = sample_count_r + 1'b1;
    // The compare also closes a window that was shrunk below the samples taken.
    window_end = (smp_upd >= limit);

    last_level_nxt   = last_level_r;
    change_count_nxt = change_count_r;
    sample_count_nxt = sample_count_r;
    win_changes_nxt  = win_changes_r;
    win_valid_nxt    = win_valid_r && !win_ready;

    if (accept) begin
      if (window_end) begin
        // Each new window starts from a low level and empty counts.
        last_level_nxt   = 1'b0;
        change_count_nxt = '0;
        sample_count_nxt = '0;
        win_changes_nxt  = chg_upd;
        win_valid_nxt    = 1'b1;
      end else begin
        last_level_nxt   = in_pin_level;
        change_count_nxt = chg_upd;
        sample_count_nxt = smp_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_level_r   <= 1'b0;
      change_count_r <= '0;
      sample_count_r <= '0;
      win_valid_r    <= 1'b0;
    end else begin
      last_level_r   <= last_level_nxt;
      change_count_r <= change_count_nxt;
      sample_count_r <= sample_count_nxt;
      win_valid_r    <= win_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    win_changes_r <= win_changes_nxt;
  end

endmodule

// File: sv/fpwc_rate.sv
// Rate stage: divides the window change count by 18 with a reciprocal multiply.
// Depends on fpwc_pkg.
module fpwc_rate (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              win_valid,
  output logic              win_ready,
  input  fpwc_pkg::count_t  win_changes,
  output logic              rate_valid,
  input  logic              rate_ready,
  output fpwc_pkg::rate_t   rate
);

  logic                           rate_valid_r, rate_valid_nxt;
  fpwc_pkg::rate_t                rate_r, rate_nxt;
  logic [fpwc_pkg::HALF_W-1:0]    half;
  logic [fpwc_pkg::PROD_W-1:0]    prod;
  logic                           take;

  assign win_ready  = !rate_valid_r || rate_ready;
  assign take       = win_valid && win_ready;
  assign rate_valid = rate_valid_r;
  assign rate       = rate_r;

  always_comb begin
    half = win_changes[fpwc_pkg::COUNT_W-1:1];
    prod = fpwc_pkg::PROD_W'(half) * fpwc_pkg::PROD_W'(fpwc_pkg::RATE_RECIP);
    rate_nxt = take ? prod[fpwc_pkg::RECIP_SHIFT +: fpwc_pkg::RATE_W] : rate_r;
    rate_valid_nxt = take || (rate_valid_r && !rate_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_valid_r <= 1'b0;
    end else begin
      rate_valid_r <= rate_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rate_r <= rate_nxt;
  end

endmodule

// File: sv/fpwc_class.sv
// Class stage: thresholds the rate, keeps the class history and the report
// state, and holds the result register. Depends on fpwc_pkg.
module fpwc_class #(
  parameter int unsigned HISTORY_DEPTH = 3
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              rate_valid,
  output logic              rate_ready,
  input  fpwc_pkg::rate_t   rate,
  input  fpwc_pkg::rate_t   slow_threshold,
  input  fpwc_pkg::rate_t   fast_threshold,
  output logic              res_valid,
  input  logic              res_ready,
  output fpwc_pkg::result_t res
);

  fpwc_pkg::class_t     history_r   [HISTORY_DEPTH];
  fpwc_pkg::class_t     history_nxt [HISTORY_DEPTH];
  fpwc_pkg::rep_class_t reported_r, reported_nxt;
  logic                 res_valid_r, res_valid_nxt;
  fpwc_pkg::result_t    res_r, res_nxt;

  fpwc_pkg::class_t     cls;
  logic                 stable;
  logic                 report;
  logic                 take;

  assign rate_ready = !res_valid_r || res_ready;
  assign take       = rate_valid && rate_ready;
  assign res_valid  = res_valid_r;
  assign res        = res_r;

  always_comb begin
    // The fast test has priority, even with the thresholds crossed.
    priority if (rate >= fast_threshold) begin
      cls = fpwc_pkg::CLASS_FAST;
    end else if (rate >= slow_threshold) begin
      cls = fpwc_pkg::CLASS_SLOW;
    end else begin
      cls = fpwc_pkg::CLASS_NONE;
    end

    history_nxt[0] = cls;
    for (int i = 1; i < HISTORY_DEPTH; i++) begin
      history_nxt[i] = history_r[i-1];
    end

    stable = 1'b1;
    for (int i = 1; i < HISTORY_DEPTH; i++) begin
      if (history_nxt[i] != cls) begin
        stable = 1'b0;
      end
    end

    report = stable && ({1'b0, cls} != reported_r);

    reported_nxt   = (take && report) ? {1'b0, cls} : reported_r;
    res_valid_nxt  = take || (res_valid_r && !res_ready);
    res_nxt        = res_r;
    if (take) begin
      res_nxt.flow_rate  = rate;
      res_nxt.flow_class = cls;
      res_nxt.lamp_on    = (cls != fpwc_pkg::CLASS_NONE);
      res_nxt.stable     = stable;
      res_nxt.report     = report;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
        history_r[i] <= fpwc_pkg::CLASS_NONE;
      end
      reported_r  <= fpwc_pkg::NONE_REPORTED;
      res_valid_r <= 1'b0;
    end else begin
      if (take) begin
        for (int i = 0; i < HISTORY_DEPTH; i++) begin
          history_r[i] <= history_nxt[i];
        end
      end
      reported_r  <= reported_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

endmodule

// File: sv/flow_pulse_window_classifier_unit.sv
// Top level of the flow pulse window classifier: configuration registers and
// the three pipeline stages. Depends on fpwc_pkg, fpwc_window, fpwc_rate and
// fpwc_class.
//
// The block takes one pin sample per request on the input channel and can take
// a new sample in every clock cycle while back pressure does not stall it. It
// counts level changes over a window of window_samples samples, the level
// before the first sample of each window being taken as low, so a high first
// sample counts as one change. A window of zero samples acts as a window of
// one. Only the sample that closes a window produces a result request; all
// other samples produce nothing. That result carries the rate (change count
// divided by 18, rounded down), the class (no flow, slow or fast; the fast
// threshold is tested first), a lamp flag, a stable flag that is set when the
// last HISTORY_DEPTH classes are all equal, and a report flag that is set when
// the class is stable and differs from the class reported last (none at
// reset). The window counters register the closed count at the edge that takes
// the closing sample, the reciprocal multiplier that does the division then
// registers the rate, and the classifier loads its result register, which
// offers the result request. Each stage holds one window result, so back
// pressure on the output only stalls the input once all three stages are
// full. Write the configuration registers only while no result is in flight.

module flow_pulse_window_classifier_unit #(
  parameter int unsigned HISTORY_DEPTH = 3
) (
  input  logic                            clk,
  input  logic                            rst_n,

  // Sample requests.
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_pin_level,

  // Result requests.
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [fpwc_pkg::RATE_W-1:0]     out_flow_rate,
  output logic [fpwc_pkg::CLASS_W-1:0]    out_flow_class,
  output logic                            out_lamp_on,
  output logic                            out_stable,
  output logic                            out_report,

  // Configuration writes.
  input  logic                            cfg_wr_en,
  input  logic [fpwc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fpwc_pkg::COUNT_W-1:0]    cfg_wdata
);

  fpwc_pkg::count_t  window_samples_r, window_samples_nxt;
  fpwc_pkg::rate_t   slow_threshold_r, slow_threshold_nxt;
  fpwc_pkg::rate_t   fast_threshold_r, fast_threshold_nxt;

  logic              win_valid;
  logic              win_ready;
  fpwc_pkg::count_t  win_changes;
  logic              rate_valid;
  logic              rate_ready;
  fpwc_pkg::rate_t   rate;
  fpwc_pkg::result_t res;

  // Configuration register file. Writes to an index past the last register
  // are dropped.
  always_comb begin
    window_samples_nxt = window_samples_r;
    slow_threshold_nxt = slow_threshold_r;
    fast_threshold_nxt = fast_threshold_r;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        fpwc_pkg::REG_WINDOW_SAMPLES: begin
          window_samples_nxt = cfg_wdata;
        end
        fpwc_pkg::REG_SLOW_THRESHOLD: begin
          slow_threshold_nxt = cfg_wdata[fpwc_pkg::RATE_W-1:0];
        end
        fpwc_pkg::REG_FAST_THRESHOLD: begin
          fast_threshold_nxt = cfg_wdata[fpwc_pkg::RATE_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_samples_r <= fpwc_pkg::WINDOW_SAMPLES_RST;
      slow_threshold_r <= fpwc_pkg::SLOW_THRESHOLD_RST;
      fast_threshold_r <= fpwc_pkg::FAST_THRESHOLD_RST;
    end else begin
      window_samples_r <= window_samples_nxt;
      slow_threshold_r <= slow_threshold_nxt;
      fast_threshold_r <= fast_threshold_nxt;
    end
  end

  // Stage one: change and sample counters; passes on each closed window.
  fpwc_window u_window (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_pin_level   (in_pin_level),
    .window_samples (window_samples_r),
    .win_valid      (win_valid),
    .win_ready      (win_ready),
    .win_changes    (win_changes)
  );

  // Stage two: divide the change count by 18.
  fpwc_rate u_rate (
    .clk         (clk),
    .rst_n       (rst_n),
    .win_valid   (win_valid),
    .win_ready   (win_ready),
    .win_changes (win_changes),
    .rate_valid  (rate_valid),
    .rate_ready  (rate_ready),
    .rate        (rate)
  );

  // Stage three: classify, update history and report state, register result.
  fpwc_class #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_class (
    .clk            (clk),
    .rst_n          (rst_n),
    .rate_valid     (rate_valid),
    .rate_ready     (rate_ready),
    .rate           (rate),
    .slow_threshold (slow_threshold_r),
    .fast_threshold (fast_threshold_r),
    .res_valid      (out_valid),
    .res_ready      (out_ready),
    .res            (res)
  );

  assign out_flow_rate  = res.flow_rate;
  assign out_flow_class = res.flow_class;
  assign out_lamp_on    = res.lamp_on;
  assign out_stable     = res.stable;
  assign out_report     = res.report;

endmodule

// File: tb/sv/testbench.sv
// Self-checking testbench for flow_pulse_window_classifier_unit.
// Depends on fpwc_pkg and the block's RTL; it holds its own window and class
// predictor and drives pin samples through randomized valid/ready pacing.
`timescale 1ns / 1ps

module testbench;

  // The block under test keeps a history of this many classes.
  localparam int unsigned HIST_DEPTH = 3;
  // The change count of a window is divided by this to give the rate.
  localparam int unsigned RATE_DIV = 18;
  // Settling time allowed before a register write, since samples that close no
  // window leave no trace.
  localparam int unsigned SETTLE_CYCLES = 8;
  // Length of the long receiver hold-off in the back-pressure phase.
  localparam int unsigned HOLD_CYCLES = 200;
  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned RANDOM_PHASES = 13;

  localparam fpwc_pkg::count_t COUNT_MAX = '1;
  localparam fpwc_pkg::rate_t  RATE_MAX  = '1;

  // Shapes of the pin waveform inside a window.
  typedef enum int unsigned {
    PAT_QUIET,   // pin held low: no changes at all
    PAT_HIGH,    // pin held high: only the opening change
    PAT_TOGGLE,  // pin flips every sample: the most changes a window can hold
    PAT_DENSE,   // pin flips on most samples
    PAT_NOISE    // random pin levels
  } pulse_pat_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;

  logic                           in_valid = 1'b0;
  logic                           in_ready;
  logic                           in_pin_level = 1'b0;

  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic [fpwc_pkg::RATE_W-1:0]    out_flow_rate;
  logic [fpwc_pkg::CLASS_W-1:0]   out_flow_class;
  logic                           out_lamp_on;
  logic                           out_stable;
  logic                           out_report;

  logic                           cfg_wr_en = 1'b0;
  logic [fpwc_pkg::CFG_IDX_W-1:0] cfg_index = fpwc_pkg::REG_WINDOW_SAMPLES;
  logic [fpwc_pkg::COUNT_W-1:0]   cfg_wdata = '0;

  flow_pulse_window_classifier_unit #(
    .HISTORY_DEPTH(HIST_DEPTH)
  ) DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_pin_level  (in_pin_level),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_flow_rate (out_flow_rate),
    .out_flow_class(out_flow_class),
    .out_lamp_on   (out_lamp_on),
    .out_stable    (out_stable),
    .out_report    (out_report),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor state. The register copies follow every write the stimulus makes;
  // the window state follows every sample request that the block accepts.
  // ---------------------------------------------------------------------------
  fpwc_pkg::count_t     win_len   = fpwc_pkg::WINDOW_SAMPLES_RST;
  fpwc_pkg::rate_t      slow_thr  = fpwc_pkg::SLOW_THRESHOLD_RST;
  fpwc_pkg::rate_t      fast_thr  = fpwc_pkg::FAST_THRESHOLD_RST;

  logic                 prev_level = 1'b0;
  fpwc_pkg::count_t     edge_count = '0;
  fpwc_pkg::count_t     samples_in_window = '0;
  fpwc_pkg::class_t     class_hist [HIST_DEPTH] = '{default: fpwc_pkg::CLASS_NONE};
  fpwc_pkg::rep_class_t last_reported = fpwc_pkg::NONE_REPORTED;

  // Results predicted but not yet seen on the output, oldest first.
  fpwc_pkg::result_t    window_results[$];
  // Pin samples waiting for the driver, and counts of those queued and taken.
  logic        pin_samples[$];
  int unsigned samples_queued = 0;
  int unsigned samples_taken = 0;

  // Pacing: chance in a hundred that the sender idles or the receiver stalls.
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  // Each increment asks the receiver for one long hold-off.
  int unsigned hold_requests = 0;
  int unsigned hold_served = 0;
  int unsigned hold_left = 0;

  int unsigned       failures = 0;
  int unsigned       cycles = 0;
  fpwc_pkg::result_t oldest;

  // The fast test comes first, so an inverted threshold pair still classes
  // everything at or above the fast threshold as fast.
  function automatic fpwc_pkg::class_t rate_class(input fpwc_pkg::rate_t rate);
    if (rate >= fast_thr) return fpwc_pkg::CLASS_FAST;
    if (rate >= slow_thr) return fpwc_pkg::CLASS_SLOW;
    return fpwc_pkg::CLASS_NONE;
  endfunction

  // Advances the window by one accepted sample and, when the window closes,
  // queues the result that the block must return for it.
  task automatic count_sample(input logic level);
    fpwc_pkg::count_t  limit;
    fpwc_pkg::result_t res;
    bit                same;
    // A zero window length behaves like a window of one sample.
    limit = (win_len == '0) ? fpwc_pkg::count_t'(1) : win_len;
    if (level != prev_level) edge_count = edge_count + 1'b1;
    prev_level = level;
    samples_in_window = samples_in_window + 1'b1;
    // Using >= also closes a window that a shrinking write left overfull.
    if (samples_in_window < limit) return;

    res.flow_rate = fpwc_pkg::rate_t'(edge_count / RATE_DIV);
    res.flow_class = rate_class(res.flow_rate);
    for (int i = HIST_DEPTH - 1; i > 0; i--) class_hist[i] = class_hist[i - 1];
    class_hist[0] = res.flow_class;
    same = 1'b1;
    for (int i = 1; i < HIST_DEPTH; i++)
      if (class_hist[i] != class_hist[i - 1]) same = 1'b0;
    res.lamp_on = (res.flow_class != fpwc_pkg::CLASS_NONE);
    res.stable = same;
    res.report = same && (fpwc_pkg::rep_class_t'(res.flow_class) != last_reported);
    if (res.report) last_reported = fpwc_pkg::rep_class_t'(res.flow_class);
    window_results.push_back(res);

    // Every window starts from a low pin and empty counters.
    edge_count = '0;
    samples_in_window = '0;
    prev_level = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offers queued pin samples as input requests. A request stays up
  // with its sample unchanged until the block takes it.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        count_sample(in_pin_level);
        samples_taken <= samples_taken + 1;
      end
      if (!in_valid || in_ready) begin
        if (pin_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_pin_level <= pin_samples.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic compare_field(input string name, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      failures++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: checks each accepted result request against the oldest prediction
  // and paces out_ready, including the long hold-off that fills the block.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (window_results.size() == 0) begin
          $error("result request with no window closed: rate %0d, class %0d",
                 out_flow_rate, out_flow_class);
          failures++;
        end else begin
          oldest = window_results.pop_front();
          compare_field("flow_rate", oldest.flow_rate, out_flow_rate);
          compare_field("flow_class", oldest.flow_class, out_flow_class);
          compare_field("lamp_on", oldest.lamp_on, out_lamp_on);
          compare_field("stable", oldest.stable, out_stable);
          compare_field("report", oldest.report, out_report);
        end
      end
      if (hold_served != hold_requests) begin
        hold_served <= hold_requests;
        hold_left <= HOLD_CYCLES;
        out_ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Ends a run that hangs, for instance on a result that never arrives.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------
  task automatic push_sample(input logic level);
    pin_samples.push_back(level);
    samples_queued++;
  endtask

  // Queues whole windows of the given length with one waveform shape.
  task automatic queue_windows(input int unsigned width, input int unsigned count,
                               input pulse_pat_t pat);
    logic level;
    for (int unsigned w = 0; w < count; w++) begin
      level = 1'b0;
      for (int unsigned i = 0; i < width; i++) begin
        case (pat)
          PAT_QUIET:  level = 1'b0;
          PAT_HIGH:   level = 1'b1;
          PAT_TOGGLE: level = ~level;
          PAT_DENSE:  level = ($urandom_range(3) != 0) ? ~level : level;
          default:    level = 1'($urandom_range(1));
        endcase
        push_sample(level);
      end
    end
  endtask

  // Waits until every queued sample is taken and every predicted result has
  // been seen, then lets the pipeline settle. Counts updated at an edge are
  // read before that edge's updates, so the check only ever errs late.
  task automatic wait_drained();
    while (samples_taken != samples_queued || window_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes all three registers on consecutive edges. Only called while idle.
  task automatic set_config(input fpwc_pkg::count_t win, input fpwc_pkg::rate_t slow,
                            input fpwc_pkg::rate_t fast);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= fpwc_pkg::REG_WINDOW_SAMPLES;
    cfg_wdata <= win;
    win_len = win;
    @(posedge clk);
    cfg_index <= fpwc_pkg::REG_SLOW_THRESHOLD;
    cfg_wdata <= fpwc_pkg::count_t'(slow);
    slow_thr = slow;
    @(posedge clk);
    cfg_index <= fpwc_pkg::REG_FAST_THRESHOLD;
    cfg_wdata <= fpwc_pkg::count_t'(fast);
    fast_thr = fast;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Thresholds mostly sit low so that short windows still reach every class.
  function automatic fpwc_pkg::rate_t pick_threshold();
    case ($urandom_range(5))
      0: return fpwc_pkg::rate_t'(0);
      1: return fpwc_pkg::rate_t'(1);
      2: return fpwc_pkg::rate_t'(2);
      3: return fpwc_pkg::rate_t'(3);
      4: return RATE_MAX;
      default: return fpwc_pkg::rate_t'($urandom_range(4));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Test sequence.
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned      width;
    int unsigned      windows_left;
    int unsigned      reps;
    fpwc_pkg::count_t win_reg;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset values first: a few samples into the long default window close
    // nothing. Shrinking the window below the samples already taken then makes
    // the next sample close it, with the rate counted from reset.
    push_sample(1'b1);
    push_sample(1'b1);
    push_sample(1'b0);
    push_sample(1'b1);
    wait_drained();
    set_config(fpwc_pkg::count_t'(2), fpwc_pkg::SLOW_THRESHOLD_RST,
               fpwc_pkg::FAST_THRESHOLD_RST);
    push_sample(1'b0);
    wait_drained();

    // A zero window closes on every sample; a zero slow threshold classes a
    // rate of zero as slow, and the largest fast threshold is never reached.
    set_config('0, fpwc_pkg::rate_t'(0), RATE_MAX);
    push_sample(1'b1);
    push_sample(1'b0);
    push_sample(1'b1);
    wait_drained();

    // The largest window, then shrunk mid-window to a single sample.
    set_config(COUNT_MAX, fpwc_pkg::rate_t'(1), fpwc_pkg::rate_t'(2));
    push_sample(1'b1);
    push_sample(1'b0);
    wait_drained();
    set_config(fpwc_pkg::count_t'(1), fpwc_pkg::rate_t'(1), fpwc_pkg::rate_t'(2));
    push_sample(1'b1);
    wait_drained();

    // Eighteen changes give a rate of exactly one.
    set_config(fpwc_pkg::count_t'(18), fpwc_pkg::rate_t'(1), fpwc_pkg::rate_t'(2));
    queue_windows(18, 1, PAT_TOGGLE);
    wait_drained();

    // Back pressure: every sample closes a window while the receiver holds off
    // for a long stretch, so the pipeline fills and the block stalls its input.
    set_config(fpwc_pkg::count_t'(1), fpwc_pkg::rate_t'(0), fpwc_pkg::rate_t'(1));
    @(posedge clk);
    hold_requests <= hold_requests + 1;
    for (int i = 0; i < 60; i++) push_sample(1'($urandom_range(1)));
    wait_drained();

    // Random phases. The phases cycle through the pacing modes; each draws a window
    // length and thresholds, and sends runs of windows with the same shape so that
    // the class history settles and reports happen, broken up by other shapes.
    for (int unsigned phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 80; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 80; end
        default: begin send_idle_pct = 14; stall_pct = 14; end
      endcase
      reps = $urandom_range(99);
      if (reps < 40) width = $urandom_range(1, 6);
      else if (reps < 85) width = $urandom_range(7, 40);
      else width = $urandom_range(41, 100);
      win_reg = (width == 1 && $urandom_range(1) == 1) ? '0 : fpwc_pkg::count_t'(width);
      set_config(win_reg, pick_threshold(), pick_threshold());
      windows_left = (60 / width > 3) ? 60 / width : 3;
      while (windows_left != 0) begin
        reps = $urandom_range(1, 4);
        if (reps > windows_left) reps = windows_left;
        queue_windows(width, reps, pulse_pat_t'($urandom_range(PAT_NOISE)));
        windows_left -= reps;
      end
      // The sender pauses here until every result of the phase is back.
      wait_drained();
    end

    // Default thresholds: ninety changes land exactly on the slow threshold.
    send_idle_pct = 0;
    stall_pct = 0;
    set_config(fpwc_pkg::count_t'(90), fpwc_pkg::SLOW_THRESHOLD_RST,
               fpwc_pkg::FAST_THRESHOLD_RST);
    queue_windows(90, 2, PAT_TOGGLE);
    wait_drained();

    if (failures == 0 && window_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
